### hw/rtl/prg_pkg.sv
// Shared types, register codes and fixed widths of the plane ray generator.
// No dependencies; the plane sum, the core and the testbench refer to it by scoped names.
`default_nettype none

package prg_pkg;

	localparam int COMP_W     = 20;   // one packed vector component
	localparam int NUM_COMP   = 3;
	localparam int VEC_W      = 60;
	localparam int FRAME_W    = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 60;

	localparam int SUM_W       = 24;       // saturated plane sum component
	localparam int SUM_MAX     = 8388607;
	localparam int SUM_MIN_MAG = 8388608;
	localparam int SQ_W        = 47;       // square of one sum component
	localparam int LEN_W       = 48;       // sum of three squares

	localparam int NORM_FRAC  = 14;                // fraction bits added before the root
	localparam int RAD_W      = LEN_W + NORM_FRAC; // radicand width, even
	localparam int ROOT_W     = RAD_W / 2;
	localparam int RAY_SHIFT  = 21;
	localparam int RAY_NUM_W  = SUM_W + RAY_SHIFT;
	localparam int RAY_QUO_W  = 15;
	localparam int OUT_W      = 16;
	localparam int OUT_ONE    = 16384;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER = 3'd0,
		REG_UP     = 3'd1,
		REG_RIGHT  = 3'd2,
		REG_WIDTH  = 3'd3,
		REG_HEIGHT = 3'd4
	} cfg_reg_t;

	localparam logic [VEC_W-1:0]   CENTER_RST = 60'd72057594037927936;
	localparam logic [VEC_W-1:0]   UP_RST     = 60'd68719476736;
	localparam logic [VEC_W-1:0]   RIGHT_RST  = 60'd65536;
	localparam logic [FRAME_W-1:0] WIDTH_RST  = 13'd640;
	localparam logic [FRAME_W-1:0] HEIGHT_RST = 13'd480;

	typedef logic signed [SUM_W-1:0] sum_t;

	typedef struct packed {
		sum_t x;
		sum_t y;
		sum_t z;
	} sum_vec_t;

	typedef struct packed {
		sum_vec_t          vec;
		logic [LEN_W-1:0]  len_sq;
	} plane_res_t;

	function automatic logic signed [COMP_W-1:0] get_comp(input logic [VEC_W-1:0] vec,
			input int unsigned idx);
		return vec[idx*COMP_W +: COMP_W];
	endfunction

endpackage

`default_nettype wire

### hw/rtl/prg_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// Caller guarantees num < den * 2^QUO_W. Uses no package.
`default_nettype none

module prg_div_pipe #(
	parameter int NUM_W  = 30,
	parameter int DEN_W  = 13,
	parameter int QUO_W  = 29,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [DEN_W-1:0]  den,
	input  wire logic [SIDE_W-1:0] in_side,
	output logic                   out_valid,
	output logic [QUO_W-1:0]       quo,
	output logic [SIDE_W-1:0]      out_side
);

	localparam int REM_W = DEN_W + QUO_W;

	logic              vld_s  [QUO_W];
	logic [QUO_W-1:0]  quo_s  [QUO_W];
	logic [SIDE_W-1:0] side_s [QUO_W];
	logic [REM_W-1:0]  rem_s  [QUO_W-1];
	logic [DEN_W-1:0]  den_s  [QUO_W-1];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		localparam int BIT = QUO_W - 1 - k;
		logic              vld_in;
		logic [REM_W-1:0]  rem_in;
		logic [DEN_W-1:0]  den_in;
		logic [QUO_W-1:0]  quo_in;
		logic [SIDE_W-1:0] side_in;
		logic [REM_W-1:0]  trial;
		logic [REM_W-1:0]  rem_nx;
		logic [QUO_W-1:0]  quo_nx;

		if (k == 0) begin : g_first
			assign vld_in  = in_valid;
			assign rem_in  = REM_W'(num);
			assign den_in  = den;
			assign quo_in  = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign den_in  = den_s[k-1];
			assign quo_in  = quo_s[k-1];
			assign side_in = side_s[k-1];
		end

		always_comb begin
			trial  = REM_W'(den_in) << BIT;
			rem_nx = rem_in;
			quo_nx = quo_in;
			if (rem_in >= trial) begin
				rem_nx      = rem_in - trial;
				quo_nx[BIT] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			quo_s[k]  <= quo_nx;
			side_s[k] <= side_in;
		end

		if (k < QUO_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k] <= rem_nx;
				den_s[k] <= den_in;
			end
		end
	end

	assign out_valid = vld_s[QUO_W-1];
	assign quo       = quo_s[QUO_W-1];
	assign out_side  = side_s[QUO_W-1];

endmodule

`default_nettype wire

### hw/rtl/prg_isqrt.sv
// Pipelined integer square root, floor, two radicand bits per stage.
// Carries a sideband alongside; uses no package.
`default_nettype none

module prg_isqrt #(
	parameter int RAD_W  = 62,
	parameter int SIDE_W = 73
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [RAD_W-1:0]  rad,
	input  wire logic [SIDE_W-1:0] in_side,
	output logic                   out_valid,
	output logic [RAD_W/2-1:0]     root,
	output logic [SIDE_W-1:0]      out_side
);

	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 2;

	logic              vld_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [SIDE_W-1:0] side_s [ROOT_W];
	logic [REM_W-1:0]  rem_s  [ROOT_W-1];
	logic [RAD_W-1:0]  rad_s  [ROOT_W-1];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic              vld_in;
		logic [REM_W-1:0]  rem_in;
		logic [RAD_W-1:0]  rad_in;
		logic [ROOT_W-1:0] root_in;
		logic [SIDE_W-1:0] side_in;
		logic [REM_W-1:0]  rem_try;
		logic [REM_W-1:0]  trial;
		logic [REM_W-1:0]  rem_nx;
		logic [ROOT_W-1:0] root_nx;

		if (k == 0) begin : g_first
			assign vld_in  = in_valid;
			assign rem_in  = '0;
			assign rad_in  = rad;
			assign root_in = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign root_in = root_s[k-1];
			assign side_in = side_s[k-1];
		end

		always_comb begin
			rem_try = {rem_in[ROOT_W-1:0], rad_in[RAD_W-1:RAD_W-2]};
			trial   = {root_in, 2'b01};
			if (rem_try >= trial) begin
				rem_nx  = rem_try - trial;
				root_nx = {root_in[ROOT_W-2:0], 1'b1};
			end else begin
				rem_nx  = rem_try;
				root_nx = {root_in[ROOT_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			root_s[k] <= root_nx;
			side_s[k] <= side_in;
		end

		if (k < ROOT_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k] <= rem_nx;
				rad_s[k] <= rad_in << 2;
			end
		end
	end

	assign out_valid = vld_s[ROOT_W-1];
	assign root      = root_s[ROOT_W-1];
	assign out_side  = side_s[ROOT_W-1];

endmodule

`default_nettype wire

### hw/rtl/prg_plane_sum.sv
// Plane point center + v*up + u*right, rounded and saturated, plus squared length.
// Five register stages; depends on prg_pkg.
`default_nettype none

module prg_plane_sum #(
	parameter int UV_W   = 30,
	parameter int FRAC_W = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic signed [UV_W-1:0]       uq,
	input  wire logic signed [UV_W-1:0]       vq,
	input  wire logic [prg_pkg::VEC_W-1:0]    center_vec,
	input  wire logic [prg_pkg::VEC_W-1:0]    up_vec,
	input  wire logic [prg_pkg::VEC_W-1:0]    right_vec,
	output logic                              out_valid,
	output prg_pkg::plane_res_t               res
);

	localparam int PROD_W = UV_W + prg_pkg::COMP_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int RND_W  = ACC_W + 1;
	localparam logic [RND_W-1:0] HALF    = RND_W'(1) << (FRAC_W - 1);
	localparam logic [RND_W-1:0] POS_LIM = RND_W'(prg_pkg::SUM_MAX);
	localparam logic [RND_W-1:0] NEG_LIM = RND_W'(prg_pkg::SUM_MIN_MAG);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic signed [PROD_W-1:0]          pv_s1  [prg_pkg::NUM_COMP];
	logic signed [PROD_W-1:0]          pu_s1  [prg_pkg::NUM_COMP];
	logic signed [prg_pkg::COMP_W-1:0] c_s1   [prg_pkg::NUM_COMP];
	logic signed [ACC_W-1:0]           acc_s2 [prg_pkg::NUM_COMP];
	prg_pkg::sum_t                     sum_s3 [prg_pkg::NUM_COMP];
	prg_pkg::sum_t                     sum_s4 [prg_pkg::NUM_COMP];
	logic [prg_pkg::SQ_W-1:0]          sq_s4  [prg_pkg::NUM_COMP];
	prg_pkg::sum_t                     sum_s5 [prg_pkg::NUM_COMP];
	logic [prg_pkg::LEN_W-1:0]         len_s5;

	prg_pkg::sum_t            sat_c [prg_pkg::NUM_COMP];
	logic [2*prg_pkg::SUM_W-1:0] sq_c [prg_pkg::NUM_COMP];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// round half away from zero, then clip to the sum range
	always_comb begin
		for (int k = 0; k < prg_pkg::NUM_COMP; k++) begin
			logic [ACC_W-1:0] mag;
			logic [RND_W-1:0] rnd;
			logic             neg;
			neg = acc_s2[k][ACC_W-1];
			mag = neg ? ACC_W'(-acc_s2[k]) : ACC_W'(acc_s2[k]);
			rnd = ({1'b0, mag} + HALF) >> FRAC_W;
			if (!neg) begin
				sat_c[k] = (rnd > POS_LIM) ? prg_pkg::SUM_W'(prg_pkg::SUM_MAX)
					: prg_pkg::SUM_W'(rnd);
			end else begin
				sat_c[k] = (rnd > NEG_LIM) ? prg_pkg::SUM_W'(prg_pkg::SUM_MIN_MAG)
					: -prg_pkg::SUM_W'(rnd);
			end
			sq_c[k] = (2*prg_pkg::SUM_W)'(sum_s3[k]) * (2*prg_pkg::SUM_W)'(sum_s3[k]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < prg_pkg::NUM_COMP; k++) begin
			pv_s1[k]  <= PROD_W'(vq) * PROD_W'(prg_pkg::get_comp(up_vec, k));
			pu_s1[k]  <= PROD_W'(uq) * PROD_W'(prg_pkg::get_comp(right_vec, k));
			c_s1[k]   <= prg_pkg::get_comp(center_vec, k);
			acc_s2[k] <= (ACC_W'(c_s1[k]) <<< FRAC_W) + ACC_W'(pv_s1[k]) + ACC_W'(pu_s1[k]);
			sum_s3[k] <= sat_c[k];
			sum_s4[k] <= sum_s3[k];
			sq_s4[k]  <= sq_c[k][prg_pkg::SQ_W-1:0];
			sum_s5[k] <= sum_s4[k];
		end
		len_s5 <= prg_pkg::LEN_W'(sq_s4[0]) + prg_pkg::LEN_W'(sq_s4[1])
			+ prg_pkg::LEN_W'(sq_s4[2]);
	end

	assign out_valid   = vld_s5;
	assign res.vec.x   = sum_s5[0];
	assign res.vec.y   = sum_s5[1];
	assign res.vec.z   = sum_s5[2];
	assign res.len_sq  = len_s5;

endmodule

`default_nettype wire

### hw/rtl/plane_ray_generator_core.sv
// Plane ray generator: pixel (x, y) in, unit view ray in signed Q1.14 out.
// Pipeline: register s1, then coordinate dividers COORD_DIV_BITS deep, where
//   COORD_DIV_BITS = max(COORD_BITS + 1, 13) + VEC_FRAC_BITS; then register s2,
//   the plane sum, the 31-stage root, s3, the 15-stage ray divider and the output.
// Throughput: one transfer per cycle; busy stays low and the receiver cannot stall.
// Reset: arst_n clears all valid bits and loads the register reset values.
`default_nettype none

module plane_ray_generator_core #(
	parameter int COORD_BITS    = 12,
	parameter int VEC_FRAC_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration writes
	input  wire logic                              cfg_wr_en,
	input  wire logic [prg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [prg_pkg::CFG_DATA_W-1:0]    cfg_data,
	// pixel command
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [COORD_BITS-1:0]             pixel_x,
	input  wire logic [COORD_BITS-1:0]             pixel_y,
	// ray result, one cycle strobe
	output logic                                   done,
	output logic signed [prg_pkg::OUT_W-1:0]       ray_x,
	output logic signed [prg_pkg::OUT_W-1:0]       ray_y,
	output logic signed [prg_pkg::OUT_W-1:0]       ray_z,
	output logic                                   degenerate
);

	// magnitude of 2x - d fits in DIFF_W bits; the quotient in DIFF_W + F bits
	localparam int DIFF_W  = (COORD_BITS + 1 > prg_pkg::FRAME_W) ? COORD_BITS + 1
		: prg_pkg::FRAME_W;
	localparam int UQ_W    = DIFF_W + VEC_FRAC_BITS;
	localparam int CNUM_W  = UQ_W + 1;
	localparam int SIDE_W  = 3 * prg_pkg::SUM_W + 1;
	localparam int NC      = prg_pkg::NUM_COMP;

	// ---------------------------------------------------------------
	// Configuration registers, read live by every stage. The user must
	// write them only while the pipe is empty; the block does not enforce it.
	// ---------------------------------------------------------------
	logic [prg_pkg::VEC_W-1:0]   center_q;
	logic [prg_pkg::VEC_W-1:0]   up_q;
	logic [prg_pkg::VEC_W-1:0]   right_q;
	logic [prg_pkg::FRAME_W-1:0] width_q;
	logic [prg_pkg::FRAME_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= prg_pkg::CENTER_RST;
			up_q     <= prg_pkg::UP_RST;
			right_q  <= prg_pkg::RIGHT_RST;
			width_q  <= prg_pkg::WIDTH_RST;
			height_q <= prg_pkg::HEIGHT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				prg_pkg::REG_CENTER: center_q <= cfg_data[prg_pkg::VEC_W-1:0];
				prg_pkg::REG_UP:     up_q     <= cfg_data[prg_pkg::VEC_W-1:0];
				prg_pkg::REG_RIGHT:  right_q  <= cfg_data[prg_pkg::VEC_W-1:0];
				prg_pkg::REG_WIDTH:  width_q  <= cfg_data[prg_pkg::FRAME_W-1:0];
				prg_pkg::REG_HEIGHT: height_q <= cfg_data[prg_pkg::FRAME_W-1:0];
				default: ;  // drop writes to unused indexes
			endcase
		end
	end

	// The pipe advances every cycle, so a command is always taken.
	assign busy = 1'b0;

	// ---------------------------------------------------------------
	// Stage s1: numerators of u = (2x - d)/d and v, d = size - 1 with
	// the size held at two or more. This stage adds d/2 first so the
	// divider's floor gives round half away from zero on the magnitude.
	// ---------------------------------------------------------------
	logic [prg_pkg::FRAME_W-1:0] dw_c, dh_c;
	logic signed [DIFF_W:0]      dx_c, dy_c;
	logic [DIFF_W-1:0]           mx_c, my_c;

	logic              vld_s1;
	logic [CNUM_W-1:0] numx_s1, numy_s1;
	logic              negx_s1, negy_s1;

	always_comb begin
		dw_c = ((width_q  < prg_pkg::FRAME_W'(2)) ? prg_pkg::FRAME_W'(2) : width_q)
			- prg_pkg::FRAME_W'(1);
		dh_c = ((height_q < prg_pkg::FRAME_W'(2)) ? prg_pkg::FRAME_W'(2) : height_q)
			- prg_pkg::FRAME_W'(1);
		dx_c = $signed((DIFF_W+1)'({pixel_x, 1'b0})) - $signed((DIFF_W+1)'(dw_c));
		dy_c = $signed((DIFF_W+1)'({pixel_y, 1'b0})) - $signed((DIFF_W+1)'(dh_c));
		mx_c = dx_c[DIFF_W] ? DIFF_W'(-dx_c) : DIFF_W'(dx_c);
		my_c = dy_c[DIFF_W] ? DIFF_W'(-dy_c) : DIFF_W'(dy_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		numx_s1 <= (CNUM_W'(mx_c) << VEC_FRAC_BITS) + CNUM_W'(dw_c >> 1);
		numy_s1 <= (CNUM_W'(my_c) << VEC_FRAC_BITS) + CNUM_W'(dh_c >> 1);
		negx_s1 <= dx_c[DIFF_W];
		negy_s1 <= dy_c[DIFF_W];
	end

	// coordinate dividers, one quotient bit per stage
	logic            udiv_vld, vdiv_vld;
	logic [UQ_W-1:0] uquo, vquo;
	logic            uneg, vneg;

	prg_div_pipe #(
		.NUM_W (CNUM_W),
		.DEN_W (prg_pkg::FRAME_W),
		.QUO_W (UQ_W),
		.SIDE_W(1)
	) u_udiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s1),
		.num      (numx_s1),
		.den      (dw_c),
		.in_side  (negx_s1),
		.out_valid(udiv_vld),
		.quo      (uquo),
		.out_side (uneg)
	);

	prg_div_pipe #(
		.NUM_W (CNUM_W),
		.DEN_W (prg_pkg::FRAME_W),
		.QUO_W (UQ_W),
		.SIDE_W(1)
	) u_vdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s1),
		.num      (numy_s1),
		.den      (dh_c),
		.in_side  (negy_s1),
		.out_valid(vdiv_vld),
		.quo      (vquo),
		.out_side (vneg)
	);

	// ---------------------------------------------------------------
	// Stage s2: restore signs of u and v.
	// ---------------------------------------------------------------
	logic                    vld_s2;
	logic signed [UQ_W:0]    uq_s2, vq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= udiv_vld && vdiv_vld;
		end
	end

	always_ff @(posedge clk) begin
		uq_s2 <= uneg ? -$signed({1'b0, uquo}) : $signed({1'b0, uquo});
		vq_s2 <= vneg ? -$signed({1'b0, vquo}) : $signed({1'b0, vquo});
	end

	// plane sum and squared length
	logic                 plane_vld;
	prg_pkg::plane_res_t  plane_res;

	prg_plane_sum #(
		.UV_W  (UQ_W + 1),
		.FRAC_W(VEC_FRAC_BITS)
	) u_plane (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.uq        (uq_s2),
		.vq        (vq_s2),
		.center_vec(center_q),
		.up_vec    (up_q),
		.right_vec (right_q),
		.out_valid (plane_vld),
		.res       (plane_res)
	);

	// n = floor(sqrt(L * 2^14)); the zero-length flag rides along
	logic                        root_vld;
	logic [prg_pkg::ROOT_W-1:0]  root_n;
	logic [SIDE_W-1:0]           root_side;
	logic                        plane_deg;

	assign plane_deg = (plane_res.len_sq == '0);

	prg_isqrt #(
		.RAD_W (prg_pkg::RAD_W),
		.SIDE_W(SIDE_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (plane_vld),
		.rad      ({plane_res.len_sq, prg_pkg::NORM_FRAC'(0)}),
		.in_side  ({plane_deg, plane_res.vec}),
		.out_valid(root_vld),
		.root     (root_n),
		.out_side (root_side)
	);

	// ---------------------------------------------------------------
	// Stage s3: ray numerators |s| * 2^21 + n/2.
	// ---------------------------------------------------------------
	prg_pkg::sum_vec_t root_vec;
	prg_pkg::sum_t     root_s [NC];

	assign root_vec  = prg_pkg::sum_vec_t'(root_side[SIDE_W-2:0]);
	assign root_s[0] = root_vec.x;
	assign root_s[1] = root_vec.y;
	assign root_s[2] = root_vec.z;

	logic                          vld_s3;
	logic                          deg_s3;
	logic [prg_pkg::ROOT_W-1:0]    n_s3;
	logic [prg_pkg::RAY_NUM_W-1:0] num_s3 [NC];
	logic                          neg_s3 [NC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= root_vld;
		end
	end

	always_ff @(posedge clk) begin
		deg_s3 <= root_side[SIDE_W-1];
		n_s3   <= root_n;
		for (int k = 0; k < NC; k++) begin
			logic [prg_pkg::SUM_W-1:0] mag;
			mag = root_s[k][prg_pkg::SUM_W-1] ? prg_pkg::SUM_W'(-root_s[k])
				: prg_pkg::SUM_W'(root_s[k]);
			num_s3[k] <= {mag, prg_pkg::RAY_SHIFT'(0)}
				+ prg_pkg::RAY_NUM_W'(root_n >> 1);
			neg_s3[k] <= root_s[k][prg_pkg::SUM_W-1];
		end
	end

	// one ray divider per component; sideband is {degenerate, sign}
	logic                          rdiv_vld  [NC];
	logic [prg_pkg::RAY_QUO_W-1:0] rdiv_quo  [NC];
	logic [1:0]                    rdiv_side [NC];

	for (genvar k = 0; k < NC; k++) begin : g_rdiv
		prg_div_pipe #(
			.NUM_W (prg_pkg::RAY_NUM_W),
			.DEN_W (prg_pkg::ROOT_W),
			.QUO_W (prg_pkg::RAY_QUO_W),
			.SIDE_W(2)
		) u_rdiv (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vld_s3),
			.num      (num_s3[k]),
			.den      (n_s3),
			.in_side  ({deg_s3, neg_s3[k]}),
			.out_valid(rdiv_vld[k]),
			.quo      (rdiv_quo[k]),
			.out_side (rdiv_side[k])
		);
	end

	// ---------------------------------------------------------------
	// Output register: clamp to one, apply sign, zero a degenerate ray.
	// ---------------------------------------------------------------
	logic signed [prg_pkg::OUT_W-1:0] ray_c [NC];

	always_comb begin
		for (int k = 0; k < NC; k++) begin
			logic [prg_pkg::OUT_W-1:0] mag;
			mag = (rdiv_quo[k] > prg_pkg::RAY_QUO_W'(prg_pkg::OUT_ONE))
				? prg_pkg::OUT_W'(prg_pkg::OUT_ONE) : prg_pkg::OUT_W'(rdiv_quo[k]);
			if (rdiv_side[k][1]) begin
				ray_c[k] = '0;
			end else if (rdiv_side[k][0]) begin
				ray_c[k] = -$signed(mag);
			end else begin
				ray_c[k] = $signed(mag);
			end
		end
	end

	logic                             done_q;
	logic                             deg_q;
	logic signed [prg_pkg::OUT_W-1:0] ray_x_q, ray_y_q, ray_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rdiv_vld[0] && rdiv_vld[1] && rdiv_vld[2];
		end
	end

	always_ff @(posedge clk) begin
		ray_x_q <= ray_c[0];
		ray_y_q <= ray_c[1];
		ray_z_q <= ray_c[2];
		deg_q   <= rdiv_side[0][1];
	end

	assign done       = done_q;
	assign ray_x      = ray_x_q;
	assign ray_y      = ray_y_q;
	assign ray_z      = ray_z_q;
	assign degenerate = deg_q;

endmodule

`default_nettype wire

### dv/tb_plane_ray_generator_core.sv
// Self-checking testbench for plane_ray_generator_core: directed and random pixel
// transfers under several plane settings, each ray checked against a local predictor.
// Depends on prg_pkg and plane_ray_generator_core.
`timescale 1ns / 100ps

module tb_plane_ray_generator_core;

	localparam int COORD_BITS  = 12;
	localparam int FRAC        = 16;
	localparam int DRAIN_WAIT  = 120;   // wait before the final check once both queues are empty
	localparam int IDLE_LIMIT  = 4000;  // cycles without any transfer or result
	localparam logic [prg_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd5;  // no register behind it
	localparam logic [prg_pkg::COMP_W-1:0] COMP_MAX  = 20'h7FFFF;
	localparam logic [prg_pkg::COMP_W-1:0] COMP_MIN  = 20'h80000;
	localparam logic [prg_pkg::COMP_W-1:0] COMP_ONE  = 20'h10000;
	localparam logic [prg_pkg::COMP_W-1:0] COMP_MONE = 20'hF0000;

	typedef enum logic [1:0] {OP_PIXEL, OP_WRITE, OP_DRAIN} op_kind_t;

	typedef struct {
		op_kind_t                       kind;
		logic [COORD_BITS-1:0]          x;
		logic [COORD_BITS-1:0]          y;
		logic [prg_pkg::CFG_IDX_W-1:0]  idx;
		logic [prg_pkg::CFG_DATA_W-1:0] data;
	} op_t;

	typedef struct {
		logic signed [prg_pkg::OUT_W-1:0] rx;
		logic signed [prg_pkg::OUT_W-1:0] ry;
		logic signed [prg_pkg::OUT_W-1:0] rz;
		logic                             deg;
	} ray_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [prg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [prg_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic start = 1'b0;
	logic [COORD_BITS-1:0] pixel_x = '0;
	logic [COORD_BITS-1:0] pixel_y = '0;
	logic busy, done, degenerate;
	logic signed [prg_pkg::OUT_W-1:0] ray_x, ray_y, ray_z;

	plane_ray_generator_core #(.COORD_BITS(COORD_BITS), .VEC_FRAC_BITS(FRAC)) uut (
		.clk, .arst_n, .cfg_wr_en, .cfg_index, .cfg_data,
		.start, .busy, .pixel_x, .pixel_y,
		.done, .ray_x, .ray_y, .ray_z, .degenerate
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Plane settings as the block should hold them; updated when a write is driven.
	logic [prg_pkg::VEC_W-1:0]   plane_center = prg_pkg::CENTER_RST;
	logic [prg_pkg::VEC_W-1:0]   plane_up     = prg_pkg::UP_RST;
	logic [prg_pkg::VEC_W-1:0]   plane_right  = prg_pkg::RIGHT_RST;
	logic [prg_pkg::FRAME_W-1:0] frame_w      = prg_pkg::WIDTH_RST;
	logic [prg_pkg::FRAME_W-1:0] frame_h      = prg_pkg::HEIGHT_RST;

	op_t  pending_ops[$];
	ray_t rays_due[$];
	int   err_count = 0;
	int   idle_cycles = 0;

	// ---------------------------------------------------------------- predictor
	function automatic longint div_half_away(longint num, longint den);
		longint mag, q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned a);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > a) bitv >>= 2;
		while (bitv != 0) begin
			if (a >= root + bitv) begin
				a -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// 2c/(size-1) - 1 with FRAC fraction bits; sizes below two act as two
	function automatic longint plane_coord(longint c, logic [prg_pkg::FRAME_W-1:0] size);
		longint d;
		d = (size < 2) ? 1 : longint'(size) - 1;
		return div_half_away((2 * c - d) * (longint'(1) << FRAC), d);
	endfunction

	function automatic longint comp_of(logic [prg_pkg::VEC_W-1:0] vec, int k);
		logic signed [prg_pkg::COMP_W-1:0] c;
		c = vec[k*prg_pkg::COMP_W +: prg_pkg::COMP_W];
		return longint'(c);
	endfunction

	function automatic ray_t predict_ray(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
		ray_t r;
		longint u, v, acc, sv, q;
		longint s[3];
		longint unsigned len_sq, norm;
		u = plane_coord(longint'(px), frame_w);
		v = plane_coord(longint'(py), frame_h);
		len_sq = 0;
		for (int k = 0; k < 3; k++) begin
			acc = comp_of(plane_center, k) * (longint'(1) << FRAC)
				+ v * comp_of(plane_up, k) + u * comp_of(plane_right, k);
			sv = div_half_away(acc, longint'(1) << FRAC);
			if (sv > prg_pkg::SUM_MAX) sv = prg_pkg::SUM_MAX;
			if (sv < -longint'(prg_pkg::SUM_MIN_MAG)) sv = -longint'(prg_pkg::SUM_MIN_MAG);
			s[k] = sv;
			len_sq += longint'(sv * sv);
		end
		if (len_sq == 0) begin
			r = '{rx: '0, ry: '0, rz: '0, deg: 1'b1};
			return r;
		end
		norm = int_sqrt(len_sq << 14);
		for (int k = 0; k < 3; k++) begin
			q = div_half_away(s[k] * (longint'(1) << 21), longint'(norm));
			if (q > prg_pkg::OUT_ONE) q = prg_pkg::OUT_ONE;
			if (q < -prg_pkg::OUT_ONE) q = -prg_pkg::OUT_ONE;
			s[k] = q;
		end
		r.rx = s[0][prg_pkg::OUT_W-1:0];
		r.ry = s[1][prg_pkg::OUT_W-1:0];
		r.rz = s[2][prg_pkg::OUT_W-1:0];
		r.deg = 1'b0;
		return r;
	endfunction

	function automatic void track_write(logic [prg_pkg::CFG_IDX_W-1:0] idx,
			logic [prg_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			prg_pkg::REG_CENTER: plane_center = data;
			prg_pkg::REG_UP:     plane_up     = data;
			prg_pkg::REG_RIGHT:  plane_right  = data;
			prg_pkg::REG_WIDTH:  frame_w      = data[prg_pkg::FRAME_W-1:0];
			prg_pkg::REG_HEIGHT: frame_h      = data[prg_pkg::FRAME_W-1:0];
			default: ;  // unmapped index: ignored by the block
		endcase
	endfunction

	// ---------------------------------------------------------------- stimulus helpers
	function automatic void add_pixel(int x, int y);
		pending_ops.push_back('{OP_PIXEL, x[COORD_BITS-1:0], y[COORD_BITS-1:0], '0, '0});
	endfunction

	function automatic void add_write(logic [prg_pkg::CFG_IDX_W-1:0] idx,
			logic [prg_pkg::CFG_DATA_W-1:0] data);
		pending_ops.push_back('{OP_WRITE, '0, '0, idx, data});
	endfunction

	function automatic void add_drain();
		pending_ops.push_back('{OP_DRAIN, '0, '0, '0, '0});
	endfunction

	function automatic logic [prg_pkg::VEC_W-1:0] pack3(logic [prg_pkg::COMP_W-1:0] a,
			logic [prg_pkg::COMP_W-1:0] b, logic [prg_pkg::COMP_W-1:0] c);
		return {c, b, a};
	endfunction

	// Mostly moderate components so rays stay away from saturation; sometimes raw bits.
	function automatic logic [prg_pkg::VEC_W-1:0] rand_vector();
		logic [prg_pkg::COMP_W-1:0] c[3];
		int mag;
		if ($urandom_range(0, 4) == 0)
			return prg_pkg::VEC_W'({$urandom, $urandom});
		for (int k = 0; k < 3; k++) begin
			mag = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 1 << 18);
			c[k] = $urandom_range(0, 1) ? prg_pkg::COMP_W'(-mag) : prg_pkg::COMP_W'(mag);
		end
		return pack3(c[0], c[1], c[2]);
	endfunction

	function automatic int rand_size();
		case ($urandom_range(0, 9))
			0: return 2;
			1: return 4096;
			2: return $urandom_range(0, 8191);  // includes sizes below two and above 4096
			default: return $urandom_range(2, 80);
		endcase
	endfunction

	// ---------------------------------------------------------------- driver
	int   gap_left = 0;
	int   burst_left = 0;
	op_t  head;
	logic nx_start, nx_wr;
	logic [COORD_BITS-1:0] nx_x, nx_y;
	logic [prg_pkg::CFG_IDX_W-1:0]  nx_idx;
	logic [prg_pkg::CFG_DATA_W-1:0] nx_data;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cfg_wr_en <= 1'b0;
			cfg_index <= '0;
			cfg_data <= '0;
			pixel_x <= '0;
			pixel_y <= '0;
		end else begin
			nx_start = start;
			nx_wr = 1'b0;
			nx_x = pixel_x;
			nx_y = pixel_y;
			nx_idx = cfg_index;
			nx_data = cfg_data;
			// A transfer at this edge: predict its ray with the settings in force now.
			if (start && !busy) begin
				rays_due.push_back(predict_ray(pixel_x, pixel_y));
				nx_start = 1'b0;
			end
			// Hold a command the block has not taken; otherwise pick the next action.
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_ops.size() > 0) begin
					head = pending_ops[0];
					case (head.kind)
						OP_PIXEL: begin
							nx_start = 1'b1;
							nx_x = head.x;
							nx_y = head.y;
							void'(pending_ops.pop_front());
							if (burst_left > 0) begin
								burst_left--;
							end else begin
								// long unbroken stretches now and then
								burst_left = $urandom_range(0, 3) == 0 ?
									$urandom_range(50, 200) : $urandom_range(0, 20);
								gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 7);
							end
						end
						OP_WRITE: begin
							// write only with nothing in flight
							if (rays_due.size() == 0) begin
								nx_wr = 1'b1;
								nx_idx = head.idx;
								nx_data = head.data;
								track_write(head.idx, head.data);
								void'(pending_ops.pop_front());
							end
						end
						default: begin
							if (rays_due.size() == 0)
								void'(pending_ops.pop_front());
						end
					endcase
				end
			end
			start <= nx_start;
			cfg_wr_en <= nx_wr;
			cfg_index <= nx_idx;
			cfg_data <= nx_data;
			pixel_x <= nx_x;
			pixel_y <= nx_y;
		end
	end

	// ---------------------------------------------------------------- monitor
	task automatic report_mismatch(string field, int got, int want);
		$display("[%0t] ray mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
		err_count++;
	endtask

	ray_t want;

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (rays_due.size() == 0) begin
				$display("[%0t] ray result with no transfer outstanding", $realtime);
				err_count++;
			end else begin
				want = rays_due.pop_front();
				if (ray_x !== want.rx) report_mismatch("ray_x", ray_x, want.rx);
				if (ray_y !== want.ry) report_mismatch("ray_y", ray_y, want.ry);
				if (ray_z !== want.rz) report_mismatch("ray_z", ray_z, want.rz);
				if (degenerate !== want.deg) report_mismatch("degenerate", degenerate, want.deg);
			end
		end
	end

	// Watchdog: end the run when neither side moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- test sequence
	initial begin
		int w, h;
		// Directed: frame corners, center and out-of-frame pixels under the reset plane.
		add_pixel(0, 0);
		add_pixel(639, 479);
		add_pixel(320, 240);
		add_pixel(4095, 4095);
		add_pixel(0, 4095);
		add_pixel(4095, 0);
		add_pixel(12'hAAA, 12'h555);
		// Unmapped index must leave every register alone.
		add_write(REG_SPARE, prg_pkg::CFG_DATA_W'({$urandom, $urandom}));
		add_pixel(1, 1);
		// Zero length: zero center, 3x3 frame, middle pixel; then a corner pixel.
		add_write(prg_pkg::REG_CENTER, '0);
		add_write(prg_pkg::REG_WIDTH, prg_pkg::CFG_DATA_W'(3));
		add_write(prg_pkg::REG_HEIGHT, prg_pkg::CFG_DATA_W'(3));
		add_pixel(1, 1);
		add_pixel(0, 2);
		// Frame sizes below two act as two; far outside pixels saturate the sum.
		add_write(prg_pkg::REG_CENTER, pack3(COMP_MAX, COMP_MIN, COMP_ONE));
		add_write(prg_pkg::REG_UP, pack3(COMP_MIN, COMP_MIN, COMP_MIN));
		add_write(prg_pkg::REG_RIGHT, pack3(COMP_MAX, COMP_MAX, COMP_MAX));
		add_write(prg_pkg::REG_WIDTH, prg_pkg::CFG_DATA_W'(0));
		add_write(prg_pkg::REG_HEIGHT, prg_pkg::CFG_DATA_W'(1));
		add_pixel(0, 0);
		add_pixel(1, 1);
		add_pixel(4095, 4095);
		add_pixel(4095, 0);
		add_write(prg_pkg::REG_RIGHT, pack3(COMP_MONE, COMP_ONE, COMP_MIN));
		add_write(prg_pkg::REG_WIDTH, prg_pkg::CFG_DATA_W'(13'h1FFF));
		add_write(prg_pkg::REG_HEIGHT, prg_pkg::CFG_DATA_W'(4096));
		add_pixel(0, 4095);
		add_pixel(4095, 2048);
		add_pixel(8, 0);

		// Random phases, each under a fresh plane.
		for (int phase = 0; phase < 10; phase++) begin
			if (phase == 4) begin
				// all-zero plane: every ray is degenerate
				add_write(prg_pkg::REG_CENTER, '0);
				add_write(prg_pkg::REG_UP, '0);
				add_write(prg_pkg::REG_RIGHT, '0);
			end else begin
				add_write(prg_pkg::REG_CENTER, rand_vector());
				add_write(prg_pkg::REG_UP, rand_vector());
				add_write(prg_pkg::REG_RIGHT, rand_vector());
			end
			w = rand_size();
			h = rand_size();
			add_write(prg_pkg::REG_WIDTH, prg_pkg::CFG_DATA_W'(prg_pkg::FRAME_W'(w)));
			add_write(prg_pkg::REG_HEIGHT, prg_pkg::CFG_DATA_W'(prg_pkg::FRAME_W'(h)));
			if ($urandom_range(0, 3) == 0)
				add_write(REG_SPARE + prg_pkg::CFG_IDX_W'($urandom_range(0, 2)),
					prg_pkg::CFG_DATA_W'({$urandom, $urandom}));
			for (int i = 0; i < 112; i++) begin
				// let the pipeline empty once mid-phase
				if (phase == 2 && i == 56)
					add_drain();
				if ($urandom_range(0, 7) == 0)
					add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
				else
					add_pixel($urandom_range(0, (w > 1 && w <= 4096) ? w - 1 : 1),
						$urandom_range(0, (h > 1 && h <= 4096) ? h - 1 : 1));
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_ops.size() == 0 && rays_due.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (rays_due.size() != 0) begin
			$display("%0d rays never arrived", rays_due.size());
			err_count++;
		end
		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### sim.f
hw/rtl/prg_pkg.sv
hw/rtl/prg_div_pipe.sv
hw/rtl/prg_isqrt.sv
hw/rtl/prg_plane_sum.sv
hw/rtl/plane_ray_generator_core.sv
dv/tb_plane_ray_generator_core.sv
